FILE: rtl/swlfc_pkg.sv
// Shared types and constants for the sync-word length-prefixed frame codec.
`default_nettype none

package swlfc_pkg;

   // Fixed frame bytes
   localparam logic [7:0] SYNC_BYTE0 = 8'hAA;
   localparam logic [7:0] SYNC_BYTE1 = 8'h55;
   localparam logic [7:0] PAD_BYTE   = 8'h88;

   // Result kinds
   localparam logic [1:0] KIND_FRAME   = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   // End status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_BAD_SYNC  = 3'd2;
   localparam logic [2:0] ST_RX_OVER   = 3'd3;
   localparam logic [2:0] ST_TX_LONG   = 3'd4;

   // Direction codes of the func field
   localparam logic FUNC_TX = 1'b0;
   localparam logic FUNC_RX = 1'b1;

   // Register indexes and reset values
   localparam logic [1:0] CFG_RX_LEN_LIMIT  = 2'd0;
   localparam logic [1:0] CFG_MAX_TX_FRAME  = 2'd1;
   localparam logic [1:0] CFG_RX_CAPACITY   = 2'd2;
   localparam logic [15:0] RX_LEN_LIMIT_RST = 16'd1024;
   localparam logic [15:0] MAX_TX_FRAME_RST = 16'd1036;
   localparam logic [15:0] RX_CAPACITY_RST  = 16'd64;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic        func;
      logic        frame_start;
      logic [7:0]  data_byte;
      logic [15:0] tx_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [2:0]  status;
      logic [15:0] delivered_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] rx_len_limit;
      logic [15:0] max_tx_frame;
      logic [15:0] rx_capacity;
   } cfg_type;

   // One classified transaction: header, one byte, padding and status, in that order
   typedef struct packed {
      logic        hdr_en;
      logic        hdr_last;
      logic [15:0] len;
      logic        byte_en;
      logic [1:0]  byte_kind;
      logic [7:0]  data;
      logic        byte_last;
      logic [1:0]  pad_cnt;
      logic        stat_en;
      logic [2:0]  stat;
      logic [15:0] count;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/sync_word_length_frame_codec.sv
// Top level of the sync-word length-prefixed frame codec.
// Framer and deframer for a link frame of HEADER_BYTES header bytes (AA 55, 16-bit
// little-endian length, zero fill), payload, and 0x88 padding to a multiple of 4.
// Input transactions carry one byte each and are classified by a front end in the
// cycle they are accepted; a 4-entry command queue feeds a back end that writes one
// result per cycle into the output register unless it is held full. Receive bytes
// stream at one per cycle likewise; a transaction with several results holds the
// back end until all are written, e.g. a transmit frame start yields HEADER_BYTES
// header bytes, its first payload byte and up to 3 padding bytes. The input reports
// full once four commands are waiting. Registers sit on the APB-style port at byte
// addresses 0 (receive length limit), 4 (max_tx_frame) and 8 (rx_capacity).
`default_nettype none

module sync_word_length_frame_codec #(
   parameter int HEADER_BYTES = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Input queue side
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire swlfc_pkg::req_type req_data,
   // Result queue side
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output swlfc_pkg::rsp_type      rsp_data,
   // Register port
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic [15:0] rx_len_limit_ff, max_tx_frame_ff, rx_capacity_ff;
   logic [1:0]  csr_index;
   logic        csr_write;
   logic [15:0] csr_rd_value;

   swlfc_pkg::cfg_type cfg;
   swlfc_pkg::cmd_type front_cmd, head_cmd;
   logic front_cmd_valid, head_valid, head_pop, queue_full, accept;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_len_limit_ff <= swlfc_pkg::RX_LEN_LIMIT_RST;
         max_tx_frame_ff <= swlfc_pkg::MAX_TX_FRAME_RST;
         rx_capacity_ff  <= swlfc_pkg::RX_CAPACITY_RST;
      end else if (csr_write) begin
         case (csr_index)
            swlfc_pkg::CFG_RX_LEN_LIMIT: rx_len_limit_ff <= csr_pwdata[15:0];
            swlfc_pkg::CFG_MAX_TX_FRAME: max_tx_frame_ff <= csr_pwdata[15:0];
            swlfc_pkg::CFG_RX_CAPACITY:  rx_capacity_ff  <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Register read
   always_comb begin
      case (csr_index)
         swlfc_pkg::CFG_RX_LEN_LIMIT: csr_rd_value = rx_len_limit_ff;
         swlfc_pkg::CFG_MAX_TX_FRAME: csr_rd_value = max_tx_frame_ff;
         swlfc_pkg::CFG_RX_CAPACITY:  csr_rd_value = rx_capacity_ff;
         default:                     csr_rd_value = 16'd0;
      endcase
      csr_prdata = {16'd0, csr_rd_value};
   end

   assign cfg = '{rx_len_limit: rx_len_limit_ff,
                  max_tx_frame: max_tx_frame_ff,
                  rx_capacity:  rx_capacity_ff};

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   swlfc_front #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cfg       (cfg),
      .cmd       (front_cmd),
      .cmd_valid (front_cmd_valid)
   );

   swlfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_cmd_valid),
      .push_cmd  (front_cmd),
      .pop       (head_pop),
      .head_cmd  (head_cmd),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   swlfc_back #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/swlfc_queue.sv
// Short command queue between the classifying front end and the emitting back end.
`default_nettype none

module swlfc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire swlfc_pkg::cmd_type push_cmd,
   input  wire logic               pop,
   output swlfc_pkg::cmd_type      head_cmd,
   output logic                    not_empty,
   output logic                    full
);

   swlfc_pkg::cmd_type entry_ff [swlfc_pkg::QUEUE_DEPTH];
   logic [swlfc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [swlfc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [swlfc_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (swlfc_pkg::QUEUE_AW+1)'(swlfc_pkg::QUEUE_DEPTH));

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/swlfc_front.sv
// Front end: tracks frame progress per input transaction and classifies it into a command.
`default_nettype none

module swlfc_front #(
   parameter int HEADER_BYTES = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire swlfc_pkg::req_type req,
   input  wire swlfc_pkg::cfg_type cfg,
   output swlfc_pkg::cmd_type      cmd,
   output logic                    cmd_valid
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TX_PAY,
      PH_RX_HDR,
      PH_RX_PAY,
      PH_RX_PAD
   } phase_type;

   phase_type   phase_ff, phase_in, eff_phase;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [1:0]  pad_ff, pad_in;
   logic [7:0]  lowb_ff, lowb_in;

   logic [15:0] eff_pos, inc_pos;
   logic [15:0] tx_plen;
   logic [1:0]  tx_pad_new, tx_pad;
   logic [16:0] tx_total;
   logic        tx_done;
   logic [15:0] rx_plen_new, cap_m1, rx_dlen_new;
   logic [1:0]  rx_pad_new;

   // Shared position step and length arithmetic
   always_comb begin
      eff_pos     = req.frame_start ? 16'd0 : pos_ff;
      inc_pos     = eff_pos + 16'd1;
      tx_pad_new  = 2'd0 - req.tx_length[1:0];
      tx_total    = {1'b0, req.tx_length} + 17'(HEADER_BYTES) + {15'd0, tx_pad_new};
      tx_plen     = req.frame_start ? req.tx_length : plen_ff;
      tx_pad      = req.frame_start ? tx_pad_new : pad_ff;
      tx_done     = (inc_pos == tx_plen);
      rx_plen_new = {req.data_byte, lowb_ff};
      cap_m1      = cfg.rx_capacity - 16'd1;
      if (cfg.rx_capacity == 16'd0) begin
         rx_dlen_new = 16'd0;
      end else if (rx_plen_new < cap_m1) begin
         rx_dlen_new = rx_plen_new;
      end else begin
         rx_dlen_new = cap_m1;
      end
      rx_pad_new = 2'd0 - rx_plen_new[1:0];
      eff_phase  = req.frame_start ? PH_RX_HDR : phase_ff;
   end

   // Frame state update and command build
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      plen_in   = plen_ff;
      dlen_in   = dlen_ff;
      pad_in    = pad_ff;
      lowb_in   = lowb_ff;
      cmd       = '0;
      cmd_valid = 1'b0;
      if (accept) begin
         if (req.func == swlfc_pkg::FUNC_TX) begin
            if (req.frame_start) begin
               // Transmit frame start: header, then the first payload byte; a too-long status instead if over the limit
               plen_in   = req.tx_length;
               pad_in    = tx_pad_new;
               pos_in    = 16'd0;
               phase_in  = PH_IDLE;
               cmd_valid = 1'b1;
               if (tx_total > {1'b0, cfg.max_tx_frame}) begin
                  cmd.stat_en = 1'b1;
                  cmd.stat    = swlfc_pkg::ST_TX_LONG;
               end else begin
                  cmd.hdr_en = 1'b1;
                  cmd.len    = req.tx_length;
                  if (req.tx_length == 16'd0) begin
                     cmd.hdr_last = 1'b1;
                  end else begin
                     phase_in = PH_TX_PAY;
                  end
               end
            end
            // Payload byte, in the start transaction or a later one
            if ((req.frame_start && cmd.hdr_en && !cmd.hdr_last) ||
                (!req.frame_start && phase_ff == PH_TX_PAY)) begin
               cmd_valid     = 1'b1;
               cmd.byte_en   = 1'b1;
               cmd.byte_kind = swlfc_pkg::KIND_FRAME;
               cmd.data      = req.data_byte;
               pos_in        = inc_pos;
               if (tx_done) begin
                  cmd.byte_last = (tx_pad == 2'd0);
                  cmd.pad_cnt   = tx_pad;
                  phase_in      = PH_IDLE;
                  pos_in        = 16'd0;
               end
            end
         end else if (req.frame_start || phase_ff == PH_RX_HDR ||
                      phase_ff == PH_RX_PAY || phase_ff == PH_RX_PAD) begin
            if (req.frame_start) begin
               phase_in = PH_RX_HDR;
               pos_in   = 16'd0;
            end
            case (eff_phase)
               PH_RX_HDR: begin
                  pos_in = inc_pos;
                  if (inc_pos >= 16'(HEADER_BYTES)) begin
                     phase_in = PH_RX_PAY;
                     pos_in   = 16'd0;
                  end
                  if ((eff_pos == 16'd0 && req.data_byte != swlfc_pkg::SYNC_BYTE0) ||
                      (eff_pos == 16'd1 && req.data_byte != swlfc_pkg::SYNC_BYTE1)) begin
                     cmd_valid   = 1'b1;
                     cmd.stat_en = 1'b1;
                     cmd.stat    = swlfc_pkg::ST_BAD_SYNC;
                     phase_in    = PH_IDLE;
                     pos_in      = 16'd0;
                  end
                  if (eff_pos == 16'd2) begin
                     lowb_in = req.data_byte;
                  end
                  if (eff_pos == 16'd3) begin
                     plen_in = rx_plen_new;
                     if (rx_plen_new == 16'd0 || rx_plen_new > cfg.rx_len_limit) begin
                        cmd_valid   = 1'b1;
                        cmd.stat_en = 1'b1;
                        cmd.stat    = (rx_plen_new == 16'd0) ? swlfc_pkg::ST_EMPTY
                                                             : swlfc_pkg::ST_RX_OVER;
                        phase_in    = PH_IDLE;
                        pos_in      = 16'd0;
                     end else begin
                        dlen_in = rx_dlen_new;
                        pad_in  = rx_pad_new;
                     end
                  end
               end
               PH_RX_PAY: begin
                  if (eff_pos < dlen_ff) begin
                     cmd_valid     = 1'b1;
                     cmd.byte_en   = 1'b1;
                     cmd.byte_kind = swlfc_pkg::KIND_DELIVER;
                     cmd.data      = req.data_byte;
                  end
                  pos_in = inc_pos;
                  if (inc_pos == plen_ff) begin
                     if (pad_ff == 2'd0) begin
                        cmd_valid   = 1'b1;
                        cmd.stat_en = 1'b1;
                        cmd.stat    = swlfc_pkg::ST_OK;
                        cmd.count   = dlen_ff;
                        phase_in    = PH_IDLE;
                        pos_in      = 16'd0;
                     end else begin
                        phase_in = PH_RX_PAD;
                     end
                  end
               end
               PH_RX_PAD: begin
                  // Padding is consumed without a check
                  pad_in = pad_ff - 2'd1;
                  if (pad_ff == 2'd1) begin
                     cmd_valid   = 1'b1;
                     cmd.stat_en = 1'b1;
                     cmd.stat    = swlfc_pkg::ST_OK;
                     cmd.count   = dlen_ff;
                     phase_in    = PH_IDLE;
                     pos_in      = 16'd0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         plen_ff  <= '0;
         dlen_ff  <= '0;
         pad_ff   <= '0;
         lowb_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         plen_ff  <= plen_in;
         dlen_ff  <= dlen_in;
         pad_ff   <= pad_in;
         lowb_ff  <= lowb_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/swlfc_back.sv
// Back end: expands queued commands into result transactions, one per cycle unless the output register is held full.
`default_nettype none

module swlfc_back #(
   parameter int HEADER_BYTES = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire swlfc_pkg::cmd_type head_cmd,
   input  wire logic               head_valid,
   output logic                    head_pop,
   input  wire logic               rsp_pop,
   output logic                    rsp_empty,
   output swlfc_pkg::rsp_type      rsp_data
);

   localparam int HIDX_W = $clog2(HEADER_BYTES + 1);

   logic [HIDX_W-1:0]  hdr_idx_ff, hdr_idx_in;
   logic               byte_done_ff, byte_done_in;
   logic [1:0]         pad_idx_ff, pad_idx_in;
   logic               valid_ff, valid_in;
   swlfc_pkg::rsp_type rsp_ff, rsp_in;

   logic hdr_act, byte_act, pad_act, piece_final, advance;
   logic [7:0] hdr_byte;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;

   // Header byte at the current index
   always_comb begin
      if (hdr_idx_ff == HIDX_W'(0)) begin
         hdr_byte = swlfc_pkg::SYNC_BYTE0;
      end else if (hdr_idx_ff == HIDX_W'(1)) begin
         hdr_byte = swlfc_pkg::SYNC_BYTE1;
      end else if (hdr_idx_ff == HIDX_W'(2)) begin
         hdr_byte = head_cmd.len[7:0];
      end else if (hdr_idx_ff == HIDX_W'(3)) begin
         hdr_byte = head_cmd.len[15:8];
      end else begin
         hdr_byte = 8'd0;
      end
   end

   // Pick the current piece of the head command and build its result
   always_comb begin
      advance  = head_valid && (!valid_ff || rsp_pop);
      hdr_act  = head_cmd.hdr_en && (hdr_idx_ff < HIDX_W'(HEADER_BYTES));
      byte_act = !hdr_act && head_cmd.byte_en && !byte_done_ff;
      pad_act  = !hdr_act && !byte_act && (pad_idx_ff < head_cmd.pad_cnt);
      rsp_in   = '0;
      if (hdr_act) begin
         rsp_in.kind     = swlfc_pkg::KIND_FRAME;
         rsp_in.out_byte = hdr_byte;
         piece_final     = (hdr_idx_ff == HIDX_W'(HEADER_BYTES - 1)) && !head_cmd.byte_en &&
                           (head_cmd.pad_cnt == 2'd0) && !head_cmd.stat_en;
         rsp_in.last     = piece_final && head_cmd.hdr_last;
      end else if (byte_act) begin
         rsp_in.kind     = head_cmd.byte_kind;
         rsp_in.out_byte = head_cmd.data;
         rsp_in.last     = head_cmd.byte_last;
         piece_final     = (head_cmd.pad_cnt == 2'd0) && !head_cmd.stat_en;
      end else if (pad_act) begin
         rsp_in.kind     = swlfc_pkg::KIND_FRAME;
         rsp_in.out_byte = swlfc_pkg::PAD_BYTE;
         rsp_in.last     = (pad_idx_ff == head_cmd.pad_cnt - 2'd1);
         piece_final     = rsp_in.last && !head_cmd.stat_en;
      end else begin
         rsp_in.kind            = swlfc_pkg::KIND_STATUS;
         rsp_in.status          = head_cmd.stat;
         rsp_in.delivered_count = head_cmd.count;
         rsp_in.last            = 1'b1;
         piece_final            = 1'b1;
      end
      head_pop = advance && piece_final;
   end

   // Progress within the head command
   always_comb begin
      hdr_idx_in   = hdr_idx_ff;
      byte_done_in = byte_done_ff;
      pad_idx_in   = pad_idx_ff;
      if (advance) begin
         if (piece_final) begin
            hdr_idx_in   = '0;
            byte_done_in = 1'b0;
            pad_idx_in   = '0;
         end else if (hdr_act) begin
            hdr_idx_in = hdr_idx_ff + 1'b1;
         end else if (byte_act) begin
            byte_done_in = 1'b1;
         end else if (pad_act) begin
            pad_idx_in = pad_idx_ff + 2'd1;
         end
      end
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff   <= '0;
         byte_done_ff <= 1'b0;
         pad_idx_ff   <= '0;
         valid_ff     <= 1'b0;
      end else begin
         hdr_idx_ff   <= hdr_idx_in;
         byte_done_ff <= byte_done_in;
         pad_idx_ff   <= pad_idx_in;
         valid_ff     <= valid_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

FILE: sim/sync_word_length_frame_codec_test.sv
// Self-checking testbench for the sync-word length-prefixed frame codec.
`default_nettype none

module sync_word_length_frame_codec_test;

   localparam int HDR_LEN        = 8;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 75;

   typedef enum logic [2:0] {
      LINK_IDLE, TX_PAYLOAD, RX_HEADER, RX_PAYLOAD, RX_PADDING
   } link_phase_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   swlfc_pkg::req_type req_data = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   swlfc_pkg::rsp_type rsp_data;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // Register copies and frame state of the predictor
   logic [15:0]    lim_rx_len, lim_tx_frame, rx_cap;
   link_phase_type link_phase;
   logic [15:0]    frame_pos, link_len, deliver_len;
   logic [1:0]     pad_left;
   logic [7:0]     len_low;

   swlfc_pkg::rsp_type expected_results[$];
   swlfc_pkg::rsp_type oldest_expected;

   int sender_idle_pct  = 0;
   int receiver_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int items_counted = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   sync_word_length_frame_codec #(.HEADER_BYTES(HDR_LEN)) DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void queue_result(logic [1:0] kind, logic [7:0] b, logic [2:0] st,
                                        logic [15:0] cnt, logic last);
      swlfc_pkg::rsp_type r;
      r.kind = kind;
      r.out_byte = b;
      r.status = st;
      r.delivered_count = cnt;
      r.last = last;
      expected_results.push_back(r);
   endfunction

   function automatic void close_frame(logic [2:0] st, logic [15:0] cnt);
      queue_result(swlfc_pkg::KIND_STATUS, 8'h00, st, cnt, 1'b1);
      link_phase = LINK_IDLE;
      frame_pos = '0;
   endfunction

   function automatic void tx_emit_payload(logic [7:0] b);
      logic done;
      frame_pos = frame_pos + 16'd1;
      done = (frame_pos == link_len);
      queue_result(swlfc_pkg::KIND_FRAME, b, swlfc_pkg::ST_OK, '0,
                   done && pad_left == 2'd0);
      if (!done) return;
      for (int i = 0; i < pad_left; i++)
         queue_result(swlfc_pkg::KIND_FRAME, swlfc_pkg::PAD_BYTE, swlfc_pkg::ST_OK, '0,
                      i + 1 == pad_left);
      link_phase = LINK_IDLE;
      frame_pos = '0;
   endfunction

   function automatic void tx_open(logic [15:0] len, logic [7:0] b);
      int pad_n;
      int total;
      logic [7:0] v;
      pad_n = (4 - (len % 4)) % 4;
      total = HDR_LEN + int'(len) + pad_n;
      link_len = len;
      pad_left = pad_n[1:0];
      frame_pos = '0;
      if (total > int'(lim_tx_frame)) begin
         close_frame(swlfc_pkg::ST_TX_LONG, '0);
         return;
      end
      for (int i = 0; i < HDR_LEN; i++) begin
         case (i)
            0: v = swlfc_pkg::SYNC_BYTE0;
            1: v = swlfc_pkg::SYNC_BYTE1;
            2: v = len[7:0];
            3: v = len[15:8];
            default: v = 8'h00;
         endcase
         queue_result(swlfc_pkg::KIND_FRAME, v, swlfc_pkg::ST_OK, '0,
                      len == 16'd0 && i == HDR_LEN - 1);
      end
      if (len == 16'd0) begin
         link_phase = LINK_IDLE;
         return;
      end
      link_phase = TX_PAYLOAD;
      tx_emit_payload(b);
   endfunction

   function automatic void rx_take(logic [7:0] b);
      logic [15:0] p;
      p = frame_pos;
      case (link_phase)
         RX_HEADER: begin
            if ((p == 16'd0 && b != swlfc_pkg::SYNC_BYTE0) ||
                (p == 16'd1 && b != swlfc_pkg::SYNC_BYTE1)) begin
               close_frame(swlfc_pkg::ST_BAD_SYNC, '0);
               return;
            end
            if (p == 16'd2) len_low = b;
            if (p == 16'd3) begin
               link_len = {b, len_low};
               if (link_len == 16'd0) begin
                  close_frame(swlfc_pkg::ST_EMPTY, '0);
                  return;
               end
               if (link_len > lim_rx_len) begin
                  close_frame(swlfc_pkg::ST_RX_OVER, '0);
                  return;
               end
               // zero capacity behaves as capacity one
               if (rx_cap == 16'd0) deliver_len = '0;
               else if (link_len < rx_cap - 16'd1) deliver_len = link_len;
               else deliver_len = rx_cap - 16'd1;
               pad_left = 2'(4 - (link_len % 4));
            end
            frame_pos = p + 16'd1;
            if (frame_pos >= HDR_LEN) begin
               link_phase = RX_PAYLOAD;
               frame_pos = '0;
            end
         end
         RX_PAYLOAD: begin
            if (p < deliver_len)
               queue_result(swlfc_pkg::KIND_DELIVER, b, swlfc_pkg::ST_OK, '0, 1'b0);
            frame_pos = p + 16'd1;
            if (frame_pos == link_len) begin
               if (pad_left == 2'd0) close_frame(swlfc_pkg::ST_OK, deliver_len);
               else link_phase = RX_PADDING;
            end
         end
         RX_PADDING: begin
            pad_left = pad_left - 2'd1;
            if (pad_left == 2'd0) close_frame(swlfc_pkg::ST_OK, deliver_len);
         end
         default: ;
      endcase
   endfunction

   // Returns 0 when the block ignores the item
   function automatic bit predict_frame_step(swlfc_pkg::req_type item);
      if (item.frame_start) begin
         link_phase = LINK_IDLE;
         frame_pos = '0;
         if (item.func == swlfc_pkg::FUNC_TX) begin
            tx_open(item.tx_length, item.data_byte);
         end else begin
            link_phase = RX_HEADER;
            rx_take(item.data_byte);
         end
         return 1'b1;
      end
      if (item.func == swlfc_pkg::FUNC_TX) begin
         if (link_phase != TX_PAYLOAD) return 1'b0;
         tx_emit_payload(item.data_byte);
      end else begin
         if (link_phase == LINK_IDLE || link_phase == TX_PAYLOAD) return 1'b0;
         rx_take(item.data_byte);
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic swlfc_pkg::req_type make_req(logic func, logic fs, logic [7:0] b,
                                                   logic [15:0] len);
      swlfc_pkg::req_type r;
      r.func = func;
      r.frame_start = fs;
      r.data_byte = b;
      r.tx_length = len;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(swlfc_pkg::req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (predict_frame_step(item)) items_counted++;
      @(negedge clock);
   endtask

   task automatic csr_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [15:0] value);
      logic [31:0] rd;
      csr_access(1'b1, idx, {16'h0000, value}, rd);
      csr_access(1'b0, idx, '0, rd);
      if (rd[15:0] !== value) begin
         $display("%0t: register %0d readback mismatch: expected %h, actual %h",
                  $time, idx, value, rd[15:0]);
         mismatch_count++;
      end
      case (idx)
         swlfc_pkg::CFG_RX_LEN_LIMIT: lim_rx_len = value;
         swlfc_pkg::CFG_MAX_TX_FRAME: lim_tx_frame = value;
         swlfc_pkg::CFG_RX_CAPACITY:  rx_cap = value;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] max_rx, logic [15:0] max_tx, logic [15:0] cap);
      write_register(swlfc_pkg::CFG_RX_LEN_LIMIT, max_rx);
      write_register(swlfc_pkg::CFG_MAX_TX_FRAME, max_tx);
      write_register(swlfc_pkg::CFG_RX_CAPACITY, cap);
   endtask

   // Drop push, wait for every expected result, then let header-only work drain
   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- result side

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: result %0d %s mismatch: expected %h, actual %h",
                  $time, results_checked, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %h byte %h status %h",
                     $time, rsp_data.kind, rsp_data.out_byte, rsp_data.status);
            mismatch_count++;
         end else begin
            oldest_expected = expected_results.pop_front();
            compare_field("kind", oldest_expected.kind, rsp_data.kind);
            compare_field("out_byte", oldest_expected.out_byte, rsp_data.out_byte);
            compare_field("status", oldest_expected.status, rsp_data.status);
            compare_field("delivered_count", oldest_expected.delivered_count,
                          rsp_data.delivered_count);
            compare_field("last", oldest_expected.last, rsp_data.last);
         end
      end
   end

   // Watchdog: cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_results.size());
            $display("sync_word_length_frame_codec regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- frame builders

   task automatic send_tx_frame();
      int choice, len, pad_n, room, sent_len;
      choice = $urandom_range(99);
      room = int'(lim_tx_frame) - HDR_LEN;
      if (choice < 60) begin
         len = $urandom_range(12);
      end else if (choice < 75 && lim_tx_frame <= 64 && room >= 0) begin
         // right at the frame limit and just past it
         len = room - $urandom_range(3) + $urandom_range(4);
         if (len < 0) len = 0;
      end else if (choice < 88) begin
         len = $urandom_range(65535);
      end else begin
         len = $urandom_range(40, 13);
      end
      pad_n = (4 - (len % 4)) % 4;
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b1, 8'($urandom_range(255)), 16'(len)));
      if (len == 0 || HDR_LEN + len + pad_n > int'(lim_tx_frame)) return;
      sent_len = (len > 40) ? $urandom_range(40, 1) : len;
      if ($urandom_range(99) < 8) sent_len = $urandom_range(sent_len, 1);
      for (int i = 1; i < sent_len; i++) begin
         if ($urandom_range(99) < 4)
            send_item(make_req(swlfc_pkg::FUNC_RX, 1'b0, 8'($urandom_range(255)),
                               16'($urandom_range(65535))));
         send_item(make_req(swlfc_pkg::FUNC_TX, 1'b0, 8'($urandom_range(255)),
                            16'($urandom_range(65535))));
      end
   endtask

   task automatic send_rx_frame();
      int choice, corrupt, len, pad_n, stop;
      logic [7:0] hdr [HDR_LEN];
      logic [7:0] b;
      choice = $urandom_range(99);
      if (choice < 62) len = $urandom_range(12, 1);
      else if (choice < 70) len = 0;
      else if (choice < 78) len = (lim_rx_len >= 1 && lim_rx_len <= 40) ?
                                  int'(lim_rx_len) : $urandom_range(12, 1);
      else if (choice < 86 && lim_rx_len < 16'hFFF0)
         len = int'(lim_rx_len) + 1 + $urandom_range(3);
      else len = $urandom_range(65535);
      pad_n = (4 - (len % 4)) % 4;
      hdr[0] = swlfc_pkg::SYNC_BYTE0;
      hdr[1] = swlfc_pkg::SYNC_BYTE1;
      hdr[2] = len[7:0];
      hdr[3] = len[15:8];
      for (int i = 4; i < HDR_LEN; i++) hdr[i] = 8'($urandom_range(255));
      corrupt = $urandom_range(99);
      if (corrupt < 6) hdr[0] = hdr[0] ^ 8'($urandom_range(255, 1));
      else if (corrupt < 12) hdr[1] = hdr[1] ^ 8'($urandom_range(255, 1));
      stop = (len > 40) ? HDR_LEN + $urandom_range(40) : HDR_LEN + len + pad_n;
      if ($urandom_range(99) < 8) stop = $urandom_range(stop, 1);
      for (int k = 0; k < stop; k++) begin
         b = (k < HDR_LEN) ? hdr[k] : 8'($urandom_range(255));
         if (k > 0 && $urandom_range(99) < 4)
            send_item(make_req(swlfc_pkg::FUNC_TX, 1'b0, 8'($urandom_range(255)),
                               16'($urandom_range(65535))));
         send_item(make_req(swlfc_pkg::FUNC_RX, k == 0, b, 16'($urandom_range(65535))));
         if (link_phase == LINK_IDLE) break;
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_tx_framing();
      // stray byte with no frame open
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b0, 8'h3C, 16'h0001));
      // header only
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b1, 8'hFF, 16'h0000));
      // largest length is always too long
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b1, 8'h00, 16'hFFFF));
      // single byte, three padding bytes
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b1, 8'hFF, 16'h0001));
      // frame exactly at the limit, abandoned by one just past it
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b1, 8'h5A, 16'd1028));
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b0, 8'hA5, 16'h0000));
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b1, 8'h00, 16'd1029));
      // two-byte frame, data on the second byte
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b1, 8'h01, 16'h0002));
      send_item(make_req(swlfc_pkg::FUNC_TX, 1'b0, 8'hFE, 16'hFFFF));
      wait_drained();
   endtask

   task automatic test_rx_deframing();
      logic [7:0] good [12] = '{8'hAA, 8'h55, 8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                8'hC3, 8'h11, 8'h22, 8'h33};
      // bad first and second sync byte
      send_item(make_req(swlfc_pkg::FUNC_RX, 1'b1, 8'h00, 16'h0000));
      send_item(make_req(swlfc_pkg::FUNC_RX, 1'b1, 8'hAA, 16'h0000));
      send_item(make_req(swlfc_pkg::FUNC_RX, 1'b0, 8'hAA, 16'h0000));
      // empty length
      foreach (good[k]) if (k < 4)
         send_item(make_req(swlfc_pkg::FUNC_RX, k == 0, (k >= 2) ? 8'h00 : good[k],
                            16'h0000));
      // oversize length
      foreach (good[k]) if (k < 4)
         send_item(make_req(swlfc_pkg::FUNC_RX, k == 0, (k >= 2) ? 8'hFF : good[k],
                            16'hFFFF));
      // one payload byte, padding skipped, transmit byte in between ignored
      foreach (good[k]) begin
         send_item(make_req(swlfc_pkg::FUNC_RX, k == 0, good[k], 16'h0000));
         if (k == 8) send_item(make_req(swlfc_pkg::FUNC_TX, 1'b0, 8'h77, 16'h0000));
      end
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 400;
      for (int i = 0; i < 6; i++)
         send_item(make_req(swlfc_pkg::FUNC_TX, 1'b1, 8'($urandom_range(255)), 16'h0001));
      wait_drained();
   endtask

   task automatic test_random_traffic(logic [15:0] max_rx, logic [15:0] max_tx,
                                      logic [15:0] cap, int send_idle, int recv_stall);
      int start, choice;
      set_config(max_rx, max_tx, cap);
      start = items_counted;
      while (items_counted - start < PHASE_ITEMS) begin
         // some frames run back to back with no idling at all
         sender_idle_pct = ($urandom_range(99) < 15) ? 0 : send_idle;
         receiver_stall_pct = ($urandom_range(99) < 15) ? 0 : recv_stall;
         choice = $urandom_range(99);
         if (choice < 45) send_tx_frame();
         else if (choice < 92) send_rx_frame();
         else send_item(make_req(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 8'($urandom_range(255)), 16'($urandom_range(65535))));
      end
      wait_drained();
   endtask

   initial begin
      lim_rx_len = swlfc_pkg::RX_LEN_LIMIT_RST;
      lim_tx_frame = swlfc_pkg::MAX_TX_FRAME_RST;
      rx_cap = swlfc_pkg::RX_CAPACITY_RST;
      link_phase = LINK_IDLE;
      frame_pos = '0;
      link_len = '0;
      deliver_len = '0;
      pad_left = '0;
      len_low = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_tx_framing();
      test_rx_deframing();
      test_output_backpressure();
      test_random_traffic(16'd1024, 16'd1036, 16'd64, 0, 0);
      test_random_traffic(16'hFFFF, 16'hFFFF, 16'hFFFF, 66, 0);
      test_random_traffic(16'd12, 16'd28, 16'd5, 0, 66);
      test_random_traffic(16'd1, 16'd8, 16'd0, 24, 24);

      receiver_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Covered %0d frame items and %0d results: framing, deframing, errors,",
               items_counted, results_checked);
      $display("four register settings, sender gaps, output stalls; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("sync_word_length_frame_codec regression: pass");
      end else begin
         $display("sync_word_length_frame_codec regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/swlfc_pkg.sv
rtl/swlfc_queue.sv
rtl/swlfc_front.sv
rtl/swlfc_back.sv
rtl/sync_word_length_frame_codec.sv
sim/sync_word_length_frame_codec_test.sv
